// ===== rtl/core/rtp_midi_cc_to_dmx_parser_unit_defines.svh =====
// Assertion macros shared by the parser unit checker.
// Expects signals named clock and reset in the scope of each use.
`ifndef RTP_MIDI_CC_TO_DMX_PARSER_UNIT_DEFINES_SVH
`define RTP_MIDI_CC_TO_DMX_PARSER_UNIT_DEFINES_SVH

// Clocked check, idle while reset is high.
`define RTPCC_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Clocked check that also runs through reset.
`define RTPCC_ASSERT_RST(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/rtpcc_pkg.sv =====
// Types and constants of the RTP-MIDI control change parser.
// No dependencies.
package rtpcc_pkg;

   localparam logic [15:0] POS_MAX          = 16'hFFFF;
   localparam logic [15:0] SESSION_MARK     = 16'hFFFF;
   localparam logic [15:0] CMD_INVITE       = 16'h494E;
   localparam logic [15:0] MIN_SESSION_LEN  = 16'd16;
   localparam logic [15:0] HEADER_END       = 16'd4;
   localparam logic [15:0] TOKEN_FIRST      = 16'd8;
   localparam logic [15:0] TOKEN_LAST       = 16'd10;
   localparam logic [15:0] TOKEN_POS        = 16'd11;
   // window of three bytes starting at byte 12: last byte at 14
   localparam logic [15:0] SCAN_FIRE_POS    = 16'd14;
   localparam logic [3:0]  CC_STATUS_NIBBLE = 4'hB;
   localparam logic [7:0]  CC_MAX           = 8'd127;

   localparam logic        KIND_CHANNEL     = 1'b0;
   localparam logic        KIND_INVITE      = 1'b1;

   // level = floor((255*v + 63) / 127), via reciprocal 516/2^16
   localparam logic [15:0] SCALE_MUL        = 16'd255;
   localparam logic [15:0] SCALE_ROUND      = 16'd63;
   localparam logic [25:0] RECIP_MUL        = 26'd516;
   localparam logic [16:0] SCALE_DIV        = 17'd127;

   typedef struct packed {
      logic        kind;
      logic [7:0]  channel;
      logic [7:0]  value;
      logic [31:0] token;
      logic        reply_on_data_port;
   } event_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  channel;
      logic [9:0]  level;
      logic [31:0] token;
      logic        reply_on_data_port;
   } result_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

// ===== rtl/core/rtpcc_front.sv =====
// Front end: byte position tracking, header/token capture, event classification.
// Depends on rtpcc_pkg.
module rtpcc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic                 first_of_packet,
   input  logic [15:0]          packet_length,
   input  logic                 from_data_port,
   output logic                 ev_valid,
   output rtpcc_pkg::event_type ev
);

   logic [15:0] pos_ff, pos_in;
   logic [15:0] size_ff, size_in;
   logic        port_ff, port_in;
   logic [31:0] hdr_ff, hdr_in;
   logic [23:0] tok_ff, tok_in;
   logic [7:0]  older_ff, older_in;
   logic [7:0]  newer_ff, newer_in;

   logic [15:0] pos_cur, size_cur;
   logic        port_cur;
   logic [31:0] hdr_cur;
   logic [23:0] tok_cur;
   logic [7:0]  older_cur, newer_cur;
   logic        in_range, session, invite, cc_hit;

   always_comb begin
      // a first mark restarts the datagram context before this byte is used
      pos_cur   = first_of_packet ? 16'd0 : pos_ff;
      size_cur  = first_of_packet ? packet_length : size_ff;
      port_cur  = first_of_packet ? from_data_port : port_ff;
      hdr_cur   = first_of_packet ? 32'd0 : hdr_ff;
      tok_cur   = first_of_packet ? 24'd0 : tok_ff;
      older_cur = first_of_packet ? 8'd0 : older_ff;
      newer_cur = first_of_packet ? 8'd0 : newer_ff;

      in_range = pos_cur < size_cur;

      hdr_in   = hdr_cur;
      tok_in   = tok_cur;
      older_in = older_cur;
      newer_in = newer_cur;
      if (in_range) begin
         if (pos_cur < rtpcc_pkg::HEADER_END) begin
            hdr_in = {hdr_cur[23:0], data_byte};
         end
         if (pos_cur >= rtpcc_pkg::TOKEN_FIRST && pos_cur <= rtpcc_pkg::TOKEN_LAST) begin
            tok_in = {tok_cur[15:0], data_byte};
         end
         older_in = newer_cur;
         newer_in = data_byte;
      end

      session = size_cur >= rtpcc_pkg::MIN_SESSION_LEN
                && hdr_in[31:16] == rtpcc_pkg::SESSION_MARK;
      invite  = in_range && pos_cur == rtpcc_pkg::TOKEN_POS && session
                && hdr_in[15:0] == rtpcc_pkg::CMD_INVITE;
      cc_hit  = in_range && port_cur && !session && pos_cur >= rtpcc_pkg::SCAN_FIRE_POS
                && older_cur[7:4] == rtpcc_pkg::CC_STATUS_NIBBLE
                && newer_cur <= rtpcc_pkg::CC_MAX;

      pos_in  = (pos_cur == rtpcc_pkg::POS_MAX) ? pos_cur : pos_cur + 16'd1;
      size_in = size_cur;
      port_in = port_cur;

      ev_valid = accept && (invite || cc_hit);
      if (invite) begin
         ev.kind               = rtpcc_pkg::KIND_INVITE;
         ev.channel            = 8'd0;
         ev.value              = 8'd0;
         ev.token              = {tok_cur, data_byte};
         ev.reply_on_data_port = port_cur;
      end else begin
         ev.kind               = rtpcc_pkg::KIND_CHANNEL;
         ev.channel            = newer_cur + 8'd1;
         ev.value              = data_byte;
         ev.token              = 32'd0;
         ev.reply_on_data_port = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 16'd0;
         size_ff  <= 16'd0;
         port_ff  <= 1'b0;
         hdr_ff   <= 32'd0;
         tok_ff   <= 24'd0;
         older_ff <= 8'd0;
         newer_ff <= 8'd0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         size_ff  <= size_in;
         port_ff  <= port_in;
         hdr_ff   <= hdr_in;
         tok_ff   <= tok_in;
         older_ff <= older_in;
         newer_ff <= newer_in;
      end
   end

endmodule

// ===== rtl/core/rtpcc_queue.sv =====
// Short event queue between front and back ends.
// Depends on rtpcc_pkg.
module rtpcc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  rtpcc_pkg::event_type     wr_data,
   input  logic                     rd_en,
   output rtpcc_pkg::event_type     rd_data,
   output rtpcc_pkg::q_status_type  status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   rtpcc_pkg::event_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   always_comb begin
      status.empty = count_ff == '0;
      status.full  = count_ff == FULL_CNT;
      do_wr = wr_en && !status.full;
      do_rd = rd_en && !status.empty;
      wr_ptr_in = do_wr ? ((wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? ((rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
      rd_data = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/core/rtpcc_back.sv =====
// Back end: level scaling in two stages and the result register.
// Depends on rtpcc_pkg.
module rtpcc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  ev_valid,
   input  rtpcc_pkg::event_type  ev,
   output logic                  ev_take,
   output logic                  out_valid,
   output rtpcc_pkg::result_type out,
   input  logic                  out_pop
);

   logic                  s1_valid_ff, s1_valid_in;
   rtpcc_pkg::event_type  s1_ev_ff;
   logic [15:0]           s1_y_ff, y_in;
   logic [9:0]            s1_q_ff, q_in;
   logic                  out_valid_ff, out_valid_in;
   rtpcc_pkg::result_type out_ff, out_in;

   logic        advance, s1_load;
   logic [25:0] prod;
   logic [16:0] q_times_div, rem;
   logic [9:0]  level;

   always_comb begin
      advance = !out_valid_ff || out_pop;
      s1_load = !s1_valid_ff || advance;
      ev_take = s1_load && ev_valid;
      s1_valid_in = s1_load ? ev_valid : s1_valid_ff;

      // stage 1: y = 255*v + 63, quotient estimate y*516 >> 16 (low by at most 1)
      y_in = 16'({8'd0, ev.value} * rtpcc_pkg::SCALE_MUL) + rtpcc_pkg::SCALE_ROUND;
      prod = 26'(y_in) * rtpcc_pkg::RECIP_MUL;
      q_in = prod[25:16];

      // stage 2: one correction step
      q_times_div = 17'(s1_q_ff) * rtpcc_pkg::SCALE_DIV;
      rem         = 17'(s1_y_ff) - q_times_div;
      level       = (rem >= rtpcc_pkg::SCALE_DIV) ? s1_q_ff + 10'd1 : s1_q_ff;

      out_in.kind               = s1_ev_ff.kind;
      out_in.channel            = s1_ev_ff.channel;
      out_in.level              = (s1_ev_ff.kind == rtpcc_pkg::KIND_INVITE) ? 10'd0 : level;
      out_in.token              = s1_ev_ff.token;
      out_in.reply_on_data_port = s1_ev_ff.reply_on_data_port;
      out_valid_in = advance ? s1_valid_ff : out_valid_ff;

      out_valid = out_valid_ff;
      out       = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ev_ff <= ev;
         s1_y_ff  <= y_in;
         s1_q_ff  <= q_in;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

endmodule

// ===== rtl/core/rtp_midi_cc_to_dmx_parser_unit.sv =====
// Top level of the RTP-MIDI control change to DMX parser.
// Depends on rtpcc_pkg, rtpcc_front, rtpcc_queue, rtpcc_back.
//
//   channel   direction  handshake          payload
//   req_*     in         push / full        data_byte, first_of_packet,
//                                           packet_length, from_data_port
//   rsp_*     out        empty / pop        event_kind, channel, level,
//                                           token, reply_on_data_port
//
// One byte per cycle is taken while full is low; the front end classifies it in
// the cycle of the transfer and queues at most one event.
// A result reaches rsp_* through the queue, the scale stage and the result
// register; one result leaves per cycle while pop is high.
// full rises when the event queue holds QUEUE_DEPTH events; every byte then waits.
// Synchronous reset clears position, datagram context and all valid state.
module rtp_midi_cc_to_dmx_parser_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_of_packet,
   input  logic [15:0] req_packet_length,
   input  logic        req_from_data_port,
   input  logic        push,
   output logic        full,
   output logic        rsp_event_kind,
   output logic [7:0]  rsp_channel,
   output logic [9:0]  rsp_level,
   output logic [31:0] rsp_token,
   output logic        rsp_reply_on_data_port,
   output logic        empty,
   input  logic        pop
);

   rtpcc_pkg::event_type    front_ev, queue_ev;
   rtpcc_pkg::q_status_type queue_status;
   rtpcc_pkg::result_type   result;
   logic                    accept, front_valid, back_take, result_valid;

   // a byte transfer happens whenever push is high and the queue has room
   assign accept = push && !queue_status.full;
   assign full   = queue_status.full;

   rtpcc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .data_byte       (req_data_byte),
      .first_of_packet (req_first_of_packet),
      .packet_length   (req_packet_length),
      .from_data_port  (req_from_data_port),
      .ev_valid        (front_valid),
      .ev              (front_ev)
   );

   // decouples classification from the scaling pipeline
   rtpcc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_valid),
      .wr_data (front_ev),
      .rd_en   (back_take),
      .rd_data (queue_ev),
      .status  (queue_status)
   );

   rtpcc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .ev_valid  (!queue_status.empty),
      .ev        (queue_ev),
      .ev_take   (back_take),
      .out_valid (result_valid),
      .out       (result),
      .out_pop   (pop)
   );

   assign empty                  = !result_valid;
   assign rsp_event_kind         = result.kind;
   assign rsp_channel            = result.channel;
   assign rsp_level              = result.level;
   assign rsp_token              = result.token;
   assign rsp_reply_on_data_port = result.reply_on_data_port;

endmodule

// ===== rtl/core/rtpcc_checker.sv =====
// Port-level checks of the parser unit, bound to the top level.
// Depends on rtp_midi_cc_to_dmx_parser_unit_defines.svh.
`include "rtp_midi_cc_to_dmx_parser_unit_defines.svh"

module rtpcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        full,
   input logic        rsp_event_kind,
   input logic [7:0]  rsp_channel,
   input logic [9:0]  rsp_level,
   input logic [31:0] rsp_token,
   input logic        rsp_reply_on_data_port,
   input logic        empty,
   input logic        pop
);

   // reset leaves nothing to deliver and room for bytes
   `RTPCC_ASSERT_RST(a_reset_idle, reset |=> empty && !full, "not idle after reset")

   // the queue only fills while a result is stuck at the output
   `RTPCC_ASSERT(a_full_needs_result, full |-> !empty, "queue full with no result shown")

   // stalled result holds its contents
   `RTPCC_ASSERT(a_result_holds, !empty && !pop |=> !empty && $stable(rsp_token) && $stable(rsp_level) && $stable(rsp_channel), "stalled result changed")

   // channel events carry a real channel, no token, no data-port reply and a level up to 512
   `RTPCC_ASSERT(a_channel_form, !empty && !rsp_event_kind |-> rsp_channel != 8'd0 && rsp_token == 32'd0 && !rsp_reply_on_data_port && rsp_level <= 10'd512, "malformed channel event")

endmodule

bind rtp_midi_cc_to_dmx_parser_unit rtpcc_checker u_checker (
   .clock                  (clock),
   .reset                  (reset),
   .full                   (full),
   .rsp_event_kind         (rsp_event_kind),
   .rsp_channel            (rsp_channel),
   .rsp_level              (rsp_level),
   .rsp_token              (rsp_token),
   .rsp_reply_on_data_port (rsp_reply_on_data_port),
   .empty                  (empty),
   .pop                    (pop)
);

// ===== tb/sv/tb_rtp_midi_cc_to_dmx_parser_unit.sv =====
// Self-checking testbench for rtp_midi_cc_to_dmx_parser_unit: datagram bytes in,
// invitation and control change events out, checked against an in-bench predictor.
// Depends on rtpcc_pkg and the parser unit RTL.
`timescale 1ns / 100ps

module tb_rtp_midi_cc_to_dmx_parser_unit;

   // Cycles without any transfer before the run is declared hung. The longest
   // legal quiet stretch is reset plus a short random idle run, far below this.
   localparam int QUIET_LIMIT = 4000;
   // Bytes of random stimulus per idling phase.
   localparam int PHASE_BYTES = 450;
   // Result path runs through the queue, scale stage and result register; leave margin for the final settle.
   localparam int SETTLE_CYCLES = 10;

   // Byte-level model of the parser plus the queue of events it predicts.
   class parser_scoreboard;
      logic [15:0]            position;
      logic [15:0]            size;
      logic                   data_port;
      logic [31:0]            header;
      logic [23:0]            token_hi;
      logic [7:0]             older;
      logic [7:0]             newer;
      rtpcc_pkg::result_type  expected_events[$];
      int                     errors;
      int                     cc_matched;
      int                     invite_matched;

      function new();
         position = '0;
         size = '0;
         data_port = 1'b0;
         header = '0;
         token_hi = '0;
         older = '0;
         newer = '0;
         errors = 0;
         cc_matched = 0;
         invite_matched = 0;
      endfunction

      function bit in_session();
         return size >= rtpcc_pkg::MIN_SESSION_LEN
                && header[31:16] == rtpcc_pkg::SESSION_MARK;
      endfunction

      // One accepted byte: update datagram context, queue any event it causes.
      function void note_byte(logic [7:0] b, logic first, logic [15:0] len, logic port);
         rtpcc_pkg::result_type ev;
         int unsigned           scaled;
         if (first) begin
            position = '0;
            size = len;
            data_port = port;
            header = '0;
            token_hi = '0;
            older = '0;
            newer = '0;
         end
         if (position < size) begin
            if (position < rtpcc_pkg::HEADER_END)
               header = {header[23:0], b};
            if (position >= rtpcc_pkg::TOKEN_FIRST && position <= rtpcc_pkg::TOKEN_LAST)
               token_hi = {token_hi[15:0], b};
            if (position == rtpcc_pkg::TOKEN_POS && in_session()
                && header[15:0] == rtpcc_pkg::CMD_INVITE) begin
               ev = '{kind: rtpcc_pkg::KIND_INVITE, channel: 8'd0, level: 10'd0,
                      token: {token_hi, b}, reply_on_data_port: data_port};
               expected_events.push_back(ev);
            end else if (data_port && !in_session() && position >= rtpcc_pkg::SCAN_FIRE_POS &&
                         older[7:4] == rtpcc_pkg::CC_STATUS_NIBBLE &&
                         newer <= rtpcc_pkg::CC_MAX) begin
               // v*255/127 rounded to nearest
               scaled = (510 * int'(b) + 127) / 254;
               ev = '{kind: rtpcc_pkg::KIND_CHANNEL, channel: newer + 8'd1,
                      level: scaled[9:0], token: 32'd0, reply_on_data_port: 1'b0};
               expected_events.push_back(ev);
            end
            older = newer;
            newer = b;
         end
         if (position != rtpcc_pkg::POS_MAX)
            position++;
      endfunction

      function void flag(string field, logic [31:0] want_v, logic [31:0] got_v);
         if (got_v !== want_v) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want_v, got_v);
         end
      endfunction

      // One accepted result: compare with the oldest predicted event.
      function void check_event(rtpcc_pkg::result_type got);
         rtpcc_pkg::result_type want;
         if (expected_events.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual kind %0d channel %0d",
                     $time, got.kind, got.channel);
            $display("   level %0d token %h reply_on_data_port %0d",
                     got.level, got.token, got.reply_on_data_port);
            return;
         end
         want = expected_events.pop_front();
         flag("event_kind", want.kind, got.kind);
         flag("channel", want.channel, got.channel);
         flag("level", want.level, got.level);
         flag("token", want.token, got.token);
         flag("reply_on_data_port", want.reply_on_data_port, got.reply_on_data_port);
         if (want.kind == rtpcc_pkg::KIND_INVITE)
            invite_matched++;
         else
            cc_matched++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic [7:0]  req_data_byte;
   logic        req_first_of_packet;
   logic [15:0] req_packet_length;
   logic        req_from_data_port;
   logic        push;
   logic        full;
   logic        rsp_event_kind;
   logic [7:0]  rsp_channel;
   logic [9:0]  rsp_level;
   logic [31:0] rsp_token;
   logic        rsp_reply_on_data_port;
   logic        empty;
   logic        pop = 1'b0;

   parser_scoreboard sb;
   logic [7:0]       dgram[$];     // datagram under construction
   int               idle_pct = 0; // chance per cycle that the sender holds off
   int               stall_pct = 0;// chance per cycle that the receiver stalls
   int               sent_bytes = 0;
   int               datagrams = 0;
   int               quiet_cycles = 0;
   int               idle_plan[4] = '{0, 58, 0, 12};
   int               stall_plan[4] = '{0, 0, 58, 12};

   rtp_midi_cc_to_dmx_parser_unit u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_data_byte          (req_data_byte),
      .req_first_of_packet    (req_first_of_packet),
      .req_packet_length      (req_packet_length),
      .req_from_data_port     (req_from_data_port),
      .push                   (push),
      .full                   (full),
      .rsp_event_kind         (rsp_event_kind),
      .rsp_channel            (rsp_channel),
      .rsp_level              (rsp_level),
      .rsp_token              (rsp_token),
      .rsp_reply_on_data_port (rsp_reply_on_data_port),
      .empty                  (empty),
      .pop                    (pop)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: pop decided at the falling edge, random stalls per phase.
   always @(negedge clock) begin
      pop <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // Monitor: both transfers sampled at the rising edge, before the DUT updates.
   // Bytes are noted before results are checked; a result never comes out in the
   // cycle of its own byte, so the order only matters for bookkeeping.
   always @(posedge clock) begin
      if (!reset && push && !full)
         sb.note_byte(req_data_byte, req_first_of_packet, req_packet_length,
                      req_from_data_port);
      if (!reset && pop && !empty)
         sb.check_event('{kind: rsp_event_kind, channel: rsp_channel, level: rsp_level,
                          token: rsp_token, reply_on_data_port: rsp_reply_on_data_port});
      if (!reset && ((push && !full) || (pop && !empty)))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: watchdog: no transfer for %0d cycles, %0d results outstanding",
                  $time, QUIET_LIMIT, sb.expected_events.size());
         $display("status: fail");
         $finish;
      end
   end

   // One byte transfer. Random hold-off first, then drive at the falling edge
   // and wait for the rising edge where full is low. push stays high after the
   // transfer; the next call either replaces the byte or drops push.
   task automatic send_byte(input logic [7:0] b, input logic first,
                            input logic [15:0] len, input logic port);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         push <= 1'b0;
      end
      @(negedge clock);
      push <= 1'b1;
      req_data_byte <= b;
      req_first_of_packet <= first;
      req_packet_length <= len;
      req_from_data_port <= port;
      @(posedge clock);
      while (full)
         @(posedge clock);
      sent_bytes++;
   endtask

   // Sends dgram. With noisy set, length and port wobble on later bytes; the
   // parser must only honor what came with the first-byte mark.
   task automatic send_datagram(input logic [15:0] len, input logic port,
                                input bit with_mark, input bit noisy);
      logic [15:0] l;
      logic        p;
      for (int i = 0; i < dgram.size(); i++) begin
         l = len;
         p = port;
         if (noisy && i != 0 && $urandom_range(3) == 0) begin
            l = 16'($urandom);
            p = 1'($urandom);
         end
         send_byte(dgram[i], with_mark && i == 0, l, p);
      end
      if (with_mark)
         datagrams++;
   endtask

   // Sender pause: drop push and hold until every predicted event is out.
   // Read at the falling edge so the monitor's update of the same cycle is in.
   task automatic drain();
      @(negedge clock);
      push <= 1'b0;
      while (sb.expected_events.size() != 0)
         @(negedge clock);
   endtask

   task automatic random_datagram();
      int          kind;
      int          n;
      logic [15:0] len;
      logic [15:0] cmd;
      logic        port;
      logic [7:0]  status;
      logic [7:0]  cc;
      logic [7:0]  v;
      kind = $urandom_range(99);
      dgram.delete();
      if (kind < 25) begin
         // invitation, token at bytes 8..11
         dgram = {rtpcc_pkg::SESSION_MARK[15:8], rtpcc_pkg::SESSION_MARK[7:0],
                  rtpcc_pkg::CMD_INVITE[15:8], rtpcc_pkg::CMD_INVITE[7:0]};
         repeat (8 + $urandom_range(0, 20)) dgram.push_back(8'($urandom));
         port = 1'($urandom);
         case ($urandom_range(7))
            0: len = 16'($urandom_range(12, 15));        // too short for a session
            1: len = 16'($urandom_range(16, 65535));     // cut off by the next mark
            default: len = (dgram.size() < 16) ? 16'd16 : 16'(dgram.size());
         endcase
         send_datagram(len, port, 1'b1, 1'b0);
      end else if (kind < 35) begin
         // session packet with some other command, often one bit off the invite
         cmd = 16'($urandom);
         if ($urandom_range(1))
            cmd = rtpcc_pkg::CMD_INVITE ^ (16'd1 << $urandom_range(15));
         dgram = {rtpcc_pkg::SESSION_MARK[15:8], rtpcc_pkg::SESSION_MARK[7:0],
                  cmd[15:8], cmd[7:0]};
         repeat (12 + $urandom_range(0, 16)) dgram.push_back(8'($urandom));
         send_datagram(16'(dgram.size()), 1'($urandom), 1'b1, 1'b0);
      end else if (kind < 85) begin
         // MIDI payload: 12 header bytes, then control change triples
         repeat (12) dgram.push_back(8'($urandom));
         if ($urandom_range(9) == 0) begin
            dgram[0] = rtpcc_pkg::SESSION_MARK[15:8];
            dgram[1] = rtpcc_pkg::SESSION_MARK[7:0];
         end else if (dgram[0] == rtpcc_pkg::SESSION_MARK[15:8]) begin
            dgram[0] = 8'h80;
         end
         n = $urandom_range(1, 8);
         repeat (n) begin
            status = ($urandom_range(4) == 0) ? 8'($urandom)
                                              : {rtpcc_pkg::CC_STATUS_NIBBLE, 4'($urandom)};
            cc = ($urandom_range(5) == 0) ? 8'($urandom_range(128, 255))
                                          : 8'($urandom_range(0, 127));
            case ($urandom_range(5))
               0: v = 8'd0;
               1: v = 8'd255;
               2: v = 8'd127;
               default: v = 8'($urandom);
            endcase
            dgram.push_back(status);
            dgram.push_back(cc);
            dgram.push_back(v);
            if ($urandom_range(4) == 0)
               dgram.push_back(8'($urandom));   // shifts the window alignment
         end
         port = ($urandom_range(7) == 0) ? 1'b0 : 1'b1;
         case ($urandom_range(7))
            0: len = 16'($urandom_range(1, dgram.size()));      // bytes past the end
            1: len = 16'(dgram.size() + $urandom_range(1, 1000)); // cut off
            default: len = 16'(dgram.size());
         endcase
         send_datagram(len, port, 1'b1, 1'b0);
      end else begin
         // noise: random bytes, sometimes with no mark, wobbling side fields
         repeat ($urandom_range(1, 30)) dgram.push_back(8'($urandom));
         len = $urandom_range(1) ? 16'($urandom_range(1, 65535))
                                 : 16'($urandom_range(1, 40));
         send_datagram(len, 1'($urandom), $urandom_range(2) != 0, 1'b1);
      end
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      push = 1'b0;
      req_data_byte = '0;
      req_first_of_packet = 1'b0;
      req_packet_length = '0;
      req_from_data_port = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: a control change pattern before any first mark (ignored).
      dgram = {{rtpcc_pkg::CC_STATUS_NIBBLE, 4'h0}, 8'h05, 8'h40};
      send_datagram(16'd40, 1'b1, 1'b0, 1'b0);

      // Invitation on the control port, cut off after the token byte.
      dgram = {rtpcc_pkg::SESSION_MARK[15:8], rtpcc_pkg::SESSION_MARK[7:0],
               rtpcc_pkg::CMD_INVITE[15:8], rtpcc_pkg::CMD_INVITE[7:0],
               8'h00, 8'h00, 8'h00, 8'h00, 8'hDE, 8'hAD, 8'hBE, 8'hEF};
      send_datagram(rtpcc_pkg::MIN_SESSION_LEN, 1'b0, 1'b1, 1'b0);

      // Data port: cc 127 at full scale, then cc 0 at zero, then a byte past the end.
      dgram = {8'h80, 8'h61, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
               8'h00, 8'h00, 8'h00, 8'h00,
               {rtpcc_pkg::CC_STATUS_NIBBLE, 4'h0}, rtpcc_pkg::CC_MAX, 8'hFF,
               {rtpcc_pkg::CC_STATUS_NIBBLE, 4'h5}, 8'h00, 8'h00,
               {rtpcc_pkg::CC_STATUS_NIBBLE, 4'hF}};
      send_datagram(16'd18, 1'b1, 1'b1, 1'b0);
      drain();

      // Random phases with different idling, each ended by a full drain.
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = idle_plan[ph];
         stall_pct = stall_plan[ph];
         n_loop: begin
            int start;
            start = sent_bytes;
            while (sent_bytes - start < PHASE_BYTES)
               random_datagram();
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.errors += sb.expected_events.size();

      $display("run covered %0d bytes in %0d marked datagrams over four idling mixes",
               sent_bytes, datagrams);
      $display("results matched: %0d control change, %0d invitation, %0d errors",
               sb.cc_matched, sb.invite_matched, sb.errors);
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
